// File: src/longest_increasing_subsequence_length_top_assert.svh
// Assertion macros for the longest increasing subsequence length block.
`ifndef LONGEST_INCREASING_SUBSEQUENCE_LENGTH_TOP_ASSERT_SVH
`define LONGEST_INCREASING_SUBSEQUENCE_LENGTH_TOP_ASSERT_SVH

// same-cycle implication
`define LISL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LISL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/lisl_pkg.sv
// Package: word types, cell control struct and default depth.
`timescale 1ns / 1ps
package lisl_pkg;

	localparam int MAX_LEN_DEF = 1024;
	localparam int LEN_BITS = 11;

	typedef struct packed {
		logic signed [31:0] value;
		logic               last;
	} item_t;

	typedef struct packed {
		logic [LEN_BITS-1:0] lis_length;
		logic                overflow;
	} result_t;

	typedef struct packed {
		logic valid;
		logic last;
		logic ovf;
	} ctl_t;

endpackage

// File: src/lisl_cell.sv
// One cell of the chain: holds one element and its ending length, updates the passing word.
`timescale 1ns / 1ps
module lisl_cell #(
	parameter int MAX_LEN = lisl_pkg::MAX_LEN_DEF,
	parameter int INDEX = 0,
	localparam int W = $clog2(MAX_LEN + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  lisl_pkg::ctl_t     ctl_i,
	input  logic signed [31:0] key_i,
	input  logic [W-1:0]       idx_i,
	input  logic [W-1:0]       acc_i,
	input  logic [W-1:0]       best_i,
	output lisl_pkg::ctl_t     ctl_o,
	output logic signed [31:0] key_o,
	output logic [W-1:0]       idx_o,
	output logic [W-1:0]       acc_o,
	output logic [W-1:0]       best_o
);
	import lisl_pkg::*;

	localparam logic [W-1:0] K = W'(INDEX);

	logic signed [31:0] val_q;
	logic [W-1:0]       len_q;
	ctl_t               ctl_q;
	logic signed [31:0] key_q;
	logic [W-1:0]       idx_q;
	logic [W-1:0]       acc_q;
	logic [W-1:0]       best_q;

	logic         hit;
	logic         at_slot;
	logic [W-1:0] new_len;
	logic [W-1:0] acc_d;
	logic [W-1:0] best_d;

	always_comb begin
		hit = K < idx_i;
		at_slot = K == idx_i;
		new_len = acc_i + W'(1);
		acc_d = acc_i;
		best_d = best_i;
		if (hit) begin
			if ((val_q < key_i) && (len_q > acc_i)) begin
				acc_d = len_q;
			end
			if (len_q > best_i) begin
				best_d = len_q;
			end
		end else if (at_slot) begin
			if (new_len > best_i) begin
				best_d = new_len;
			end
		end
	end

	// element store, written once per sequence by the word whose index matches
	always_ff @(posedge clk) begin
		if (en && ctl_i.valid && at_slot) begin
			val_q <= key_i;
			len_q <= new_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			key_q <= key_i;
			idx_q <= idx_i;
			acc_q <= acc_d;
			best_q <= best_d;
		end
	end

	assign ctl_o = ctl_q;
	assign key_o = key_q;
	assign idx_o = idx_q;
	assign acc_o = acc_q;
	assign best_o = best_q;

endmodule

// File: src/longest_increasing_subsequence_length_top.sv
// The last word crosses MAX_LEN cells; its result then enters the output register.
// Throughput: one word per cycle unless stalled; each word moves one cell per cycle.
// Stalls only while a result waits at the output and a last word is at the chain's end.
// Reset clears the element counter, overflow flag, cell valid bits and output valid;
// cell contents are not reset and need no clearing pass.
`timescale 1ns / 1ps
module longest_increasing_subsequence_length_top #(
	parameter int MAX_LEN = lisl_pkg::MAX_LEN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  lisl_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output lisl_pkg::result_t result
);
	import lisl_pkg::*;

	localparam int W = $clog2(MAX_LEN + 1);
	localparam logic [W-1:0] FULL = W'(MAX_LEN);

	logic [W-1:0] count_q;
	logic         ovf_q;
	logic         take;
	logic         adv;
	logic         tok_ovf;

	ctl_t               ctl  [0:MAX_LEN];
	logic signed [31:0] key  [0:MAX_LEN];
	logic [W-1:0]       idx  [0:MAX_LEN];
	logic [W-1:0]       acc  [0:MAX_LEN];
	logic [W-1:0]       best [0:MAX_LEN];

	logic              res_valid_q;
	result_t           res_q;
	logic [W+10:0]     best_ext;

	assign adv = !(ctl[MAX_LEN].valid && ctl[MAX_LEN].last && res_valid_q && !result_ready);
	assign item_ready = adv;
	assign take = item_valid && adv;
	assign tok_ovf = ovf_q || (count_q == FULL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q <= 1'b0;
		end else if (take) begin
			if (item.last) begin
				count_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				ovf_q <= tok_ovf;
				if (count_q != FULL) begin
					count_q <= count_q + W'(1);
				end
			end
		end
	end

	always_comb begin
		ctl[0].valid = take;
		ctl[0].last = item.last;
		ctl[0].ovf = tok_ovf;
		key[0] = item.value;
		idx[0] = count_q;
		acc[0] = '0;
		best[0] = '0;
	end

	for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
		lisl_cell #(
			.MAX_LEN(MAX_LEN),
			.INDEX(g)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(adv),
			.ctl_i(ctl[g]),
			.key_i(key[g]),
			.idx_i(idx[g]),
			.acc_i(acc[g]),
			.best_i(best[g]),
			.ctl_o(ctl[g+1]),
			.key_o(key[g+1]),
			.idx_o(idx[g+1]),
			.acc_o(acc[g+1]),
			.best_o(best[g+1])
		);
	end

	assign best_ext = {11'b0, best[MAX_LEN]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv && ctl[MAX_LEN].valid && ctl[MAX_LEN].last) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && ctl[MAX_LEN].valid && ctl[MAX_LEN].last) begin
			res_q.lis_length <= best_ext[LEN_BITS-1:0];
			res_q.overflow <= ctl[MAX_LEN].ovf;
		end
	end

	assign result_valid = res_valid_q;
	assign result = res_q;

endmodule

// File: src/lisl_checker.sv
// Port-level checker for the longest increasing subsequence length block, with its bind.
`timescale 1ns / 1ps
`include "longest_increasing_subsequence_length_top_assert.svh"
module lisl_checker #(
	parameter int MAX_LEN = lisl_pkg::MAX_LEN_DEF
) (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_ready,
	input lisl_pkg::item_t   item,
	input logic              result_valid,
	input logic              result_ready,
	input lisl_pkg::result_t result
);
	import lisl_pkg::*;

	localparam logic SHORT = MAX_LEN < 2048;

	`LISL_ASSERT_NXT(a_item_hold, clk, arst_n, item_valid && !item_ready, item_valid && $stable(item), "input word changed while stalled")
	`LISL_ASSERT_NXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(result), "result word changed while stalled")
	`LISL_ASSERT_IMP(a_stall_cause, clk, arst_n, !item_ready, result_valid && !result_ready, "input stalled without a waiting result")
	`LISL_ASSERT_IMP(a_len_nonzero, clk, arst_n, result_valid && SHORT, result.lis_length != '0, "zero length for a nonempty sequence")

endmodule

bind longest_increasing_subsequence_length_top lisl_checker #(
	.MAX_LEN(MAX_LEN)
) u_lisl_checker (
	.clk(clk),
	.arst_n(arst_n),
	.item_valid(item_valid),
	.item_ready(item_ready),
	.item(item),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.result(result)
);
